// ----- src/cfr_pkg.sv -----
// Shared types and constants of the clock frame replacement block.
`default_nettype none

package cfr_pkg;

    localparam logic [2:0] OP_ALLOC       = 3'd0;
    localparam logic [2:0] OP_FREE        = 3'd1;
    localparam logic [2:0] OP_PIN         = 3'd2;
    localparam logic [2:0] OP_UNPIN       = 3'd3;
    localparam logic [2:0] OP_FREE_OWNER  = 3'd4;
    localparam logic [2:0] OP_UNPIN_OWNER = 3'd5;
    localparam logic [2:0] OP_TOUCH       = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_OOM       = 2'd2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic       valid;
        logic       pinned;
        logic       accessed;
        logic       dirty;
        logic       mmap;
        logic [7:0] owner;
    } slot_t;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_FRAME,
        RD_HAND
    } rd_src_t;

    typedef enum logic [2:0] {
        WR_ZERO,
        WR_FILL,
        WR_PIN,
        WR_UNPIN,
        WR_TOUCH,
        WR_CLR_ACC
    } wr_kind_t;

    typedef enum logic [2:0] {
        RES_OK,
        RES_NOT_FOUND,
        RES_OOM,
        RES_GRANT,
        RES_EVICT
    } res_kind_t;

    typedef struct packed {
        logic      load_in;
        logic      scan_clear;
        logic      scan_inc;
        rd_src_t   rd_src;
        logic      hand_adv;
        logic      any_clear;
        logic      any_track;
        logic      wr_en;
        logic      wr_scan;
        wr_kind_t  wr_kind;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_push;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       frame_ok;
        slot_t      slot;
        logic       owner_match;
        logic       any_unpinned;
        logic       proc_last;
        logic       scan_last;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- src/clock_frame_replacement.sv -----
// Top level of the clock frame replacement block.
// A frame table of NUM_FRAMES slots kept in one memory with a registered read.
// After reset a clearing pass writes every slot with s_tready low. Each input
// word yields one result word. Free, pin, unpin and touch read and update one
// slot; owner-wide operations visit every slot; alloc scans for a free slot
// and, when the table is full, runs the clock sweep unless every slot is
// pinned. Scans and sweeps are paced by the single read port of the slot
// memory, which visits one slot per cycle. A new word is accepted while the
// previous result still waits on the master side.
`default_nettype none

module clock_frame_replacement #(
    parameter int NUM_FRAMES = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // operation[2:0], frame[8:3], owner[16:9], mmap_page[17], write_access[18]
    input  wire logic [cfr_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // status[1:0], granted_frame[7:2], evicted[8], victim_owner[16:9],
    // victim_writeback[17], victim_swap[18]
    output logic [cfr_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    cfr_pkg::cmd_t cmd;
    cfr_pkg::sts_t sts;

    cfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfr_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- src/cfr_datapath.sv -----
// Datapath: slot memory, scan counter, clock hand, input and result registers.
`default_nettype none

module cfr_datapath #(
    parameter int NUM_FRAMES = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire cfr_pkg::cmd_t                      cmd,
    output cfr_pkg::sts_t                           sts,
    input  wire logic [cfr_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [cfr_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = ((AW > 6) ? AW : 6) + 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_FRAMES - 1);

    cfr_pkg::slot_t slot_mem [NUM_FRAMES];

    logic [2:0]     in_op_reg;
    logic [5:0]     in_frame_reg;
    logic [7:0]     in_owner_reg;
    logic           in_mmap_reg;
    logic           in_write_reg;

    logic [AW-1:0]  scan_reg;
    logic [AW-1:0]  scan_next;
    logic [AW-1:0]  hand_reg;
    logic [AW-1:0]  hand_next;
    logic [AW-1:0]  proc_addr_reg;
    logic           any_reg;
    cfr_pkg::slot_t rdata_reg;

    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    cfr_pkg::slot_t wdata;

    logic [1:0]     res_status_reg;
    logic [5:0]     res_granted_reg;
    logic           res_evicted_reg;
    logic [7:0]     res_vowner_reg;
    logic           res_vwb_reg;
    logic           res_vswap_reg;

    logic [1:0]     res_status_next;
    logic [5:0]     res_granted_next;
    logic           res_evicted_next;
    logic [7:0]     res_vowner_next;
    logic           res_vwb_next;
    logic           res_vswap_next;

    logic [cfr_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                            out_valid_reg;

    assign scan_next = (scan_reg == LAST) ? '0 : scan_reg + AW'(1);
    assign hand_next = (hand_reg == LAST) ? '0 : hand_reg + AW'(1);

    always_comb
    begin
        unique case (cmd.rd_src)
            cfr_pkg::RD_SCAN:  rd_addr = scan_reg;
            cfr_pkg::RD_FRAME: rd_addr = AW'(in_frame_reg);
            cfr_pkg::RD_HAND:  rd_addr = hand_reg;
            default:           rd_addr = scan_reg;
        endcase
    end

    assign wr_addr = cmd.wr_scan ? scan_reg : proc_addr_reg;

    always_comb
    begin
        wdata = rdata_reg;
        unique case (cmd.wr_kind)
            cfr_pkg::WR_ZERO:
            begin
                wdata = '0;
            end
            cfr_pkg::WR_FILL:
            begin
                wdata.valid    = 1'b1;
                wdata.pinned   = 1'b1;
                wdata.accessed = 1'b0;
                wdata.dirty    = 1'b0;
                wdata.mmap     = in_mmap_reg;
                wdata.owner    = in_owner_reg;
            end
            cfr_pkg::WR_PIN:
            begin
                wdata.pinned = 1'b1;
            end
            cfr_pkg::WR_UNPIN:
            begin
                wdata.pinned = 1'b0;
            end
            cfr_pkg::WR_TOUCH:
            begin
                wdata.accessed = 1'b1;
                wdata.dirty    = rdata_reg.dirty | in_write_reg;
            end
            cfr_pkg::WR_CLR_ACC:
            begin
                wdata.accessed = 1'b0;
            end
            default:
            begin
                wdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            slot_mem[wr_addr] <= wdata;
        end
        rdata_reg     <= slot_mem[rd_addr];
        proc_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_op_reg    <= s_tdata[2:0];
            in_frame_reg <= s_tdata[8:3];
            in_owner_reg <= s_tdata[16:9];
            in_mmap_reg  <= s_tdata[17];
            in_write_reg <= s_tdata[18];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            hand_reg <= '0;
            any_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clear)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_next;
            end
            if (cmd.hand_adv)
            begin
                hand_reg <= hand_next;
            end
            if (cmd.any_clear)
            begin
                any_reg <= 1'b0;
            end
            else if (cmd.any_track)
            begin
                any_reg <= any_reg | ~rdata_reg.pinned;
            end
        end
    end

    always_comb
    begin
        res_status_next  = cfr_pkg::ST_OK;
        res_granted_next = '0;
        res_evicted_next = 1'b0;
        res_vowner_next  = '0;
        res_vwb_next     = 1'b0;
        res_vswap_next   = 1'b0;
        unique case (cmd.res_kind)
            cfr_pkg::RES_OK:
            begin
                res_status_next = cfr_pkg::ST_OK;
            end
            cfr_pkg::RES_NOT_FOUND:
            begin
                res_status_next = cfr_pkg::ST_NOT_FOUND;
            end
            cfr_pkg::RES_OOM:
            begin
                res_status_next = cfr_pkg::ST_OOM;
            end
            cfr_pkg::RES_GRANT:
            begin
                res_granted_next = 6'(proc_addr_reg);
            end
            cfr_pkg::RES_EVICT:
            begin
                res_granted_next = 6'(proc_addr_reg);
                res_evicted_next = 1'b1;
                res_vowner_next  = rdata_reg.owner;
                res_vwb_next     = rdata_reg.mmap & rdata_reg.dirty;
                res_vswap_next   = ~(rdata_reg.mmap & rdata_reg.dirty);
            end
            default:
            begin
                res_status_next = cfr_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg  <= res_status_next;
            res_granted_reg <= res_granted_next;
            res_evicted_reg <= res_evicted_next;
            res_vowner_reg  <= res_vowner_next;
            res_vwb_reg     <= res_vwb_next;
            res_vswap_reg   <= res_vswap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_push)
        begin
            out_data_reg <= {5'b0, res_vswap_reg, res_vwb_reg, res_vowner_reg,
                             res_evicted_reg, res_granted_reg, res_status_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign sts.op           = in_op_reg;
    assign sts.frame_ok     = CW'(in_frame_reg) < CW'(NUM_FRAMES);
    assign sts.slot         = rdata_reg;
    assign sts.owner_match  = rdata_reg.owner == in_owner_reg;
    assign sts.any_unpinned = any_reg | ~rdata_reg.pinned;
    assign sts.proc_last    = proc_addr_reg == LAST;
    assign sts.scan_last    = scan_reg == LAST;
    assign sts.out_free     = ~out_valid_reg | m_tready;

`ifndef SYNTHESIS
    hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hand_reg) < NUM_FRAMES)
        else $error("Clock hand left the slot range.");

    sweep_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en && cmd.rd_src == cfr_pkg::RD_HAND |-> wr_addr != rd_addr)
        else $error("Sweep reads the slot that it writes in the same cycle.");

    grant_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load && (cmd.res_kind == cfr_pkg::RES_GRANT
                         || cmd.res_kind == cfr_pkg::RES_EVICT)
        |-> cmd.wr_en && cmd.wr_kind == cfr_pkg::WR_FILL && !cmd.wr_scan)
        else $error("Granted slot was not filled.");
`endif

endmodule

`default_nettype wire

// ----- src/cfr_ctrl.sv -----
// Controller state machine that sequences scans, sweeps and slot updates.
`default_nettype none

module cfr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire cfr_pkg::sts_t sts,
    output cfr_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        CLEAR,
        IDLE,
        DECODE,
        ALLOC_SCAN,
        SWEEP_START,
        SWEEP,
        SINGLE,
        OWNER_SCAN,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_src   = cfr_pkg::RD_SCAN;
        cmd.wr_kind  = cfr_pkg::WR_ZERO;
        cmd.res_kind = cfr_pkg::RES_OK;
        unique case (state_reg)
            CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_scan  = 1'b1;
                cmd.scan_inc = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in    = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = DECODE;
                end
            end
            DECODE:
            begin
                priority if (sts.op == cfr_pkg::OP_ALLOC)
                begin
                    cmd.scan_inc  = 1'b1;
                    cmd.any_clear = 1'b1;
                    state_next    = ALLOC_SCAN;
                end
                else if (sts.op == cfr_pkg::OP_FREE || sts.op == cfr_pkg::OP_PIN
                         || sts.op == cfr_pkg::OP_UNPIN || sts.op == cfr_pkg::OP_TOUCH)
                begin
                    if (sts.frame_ok)
                    begin
                        cmd.rd_src = cfr_pkg::RD_FRAME;
                        state_next = SINGLE;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = cfr_pkg::RES_NOT_FOUND;
                        state_next   = FINISH;
                    end
                end
                else if (sts.op == cfr_pkg::OP_FREE_OWNER
                         || sts.op == cfr_pkg::OP_UNPIN_OWNER)
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = OWNER_SCAN;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = cfr_pkg::RES_OK;
                    state_next   = FINISH;
                end
            end
            ALLOC_SCAN:
            begin
                cmd.any_track = 1'b1;
                priority if (!sts.slot.valid)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_kind  = cfr_pkg::WR_FILL;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = cfr_pkg::RES_GRANT;
                    state_next   = FINISH;
                end
                else if (sts.proc_last)
                begin
                    if (sts.any_unpinned)
                    begin
                        state_next = SWEEP_START;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = cfr_pkg::RES_OOM;
                        state_next   = FINISH;
                    end
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            SWEEP_START:
            begin
                cmd.rd_src   = cfr_pkg::RD_HAND;
                cmd.hand_adv = 1'b1;
                state_next   = SWEEP;
            end
            SWEEP:
            begin
                priority if (sts.slot.pinned)
                begin
                    cmd.rd_src   = cfr_pkg::RD_HAND;
                    cmd.hand_adv = 1'b1;
                end
                else if (sts.slot.accessed)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_kind  = cfr_pkg::WR_CLR_ACC;
                    cmd.rd_src   = cfr_pkg::RD_HAND;
                    cmd.hand_adv = 1'b1;
                end
                else
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_kind  = cfr_pkg::WR_FILL;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = cfr_pkg::RES_EVICT;
                    state_next   = FINISH;
                end
            end
            SINGLE:
            begin
                cmd.res_load = 1'b1;
                state_next   = FINISH;
                if (!sts.slot.valid)
                begin
                    cmd.res_kind = cfr_pkg::RES_NOT_FOUND;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    priority if (sts.op == cfr_pkg::OP_FREE)
                    begin
                        cmd.wr_kind = cfr_pkg::WR_ZERO;
                    end
                    else if (sts.op == cfr_pkg::OP_PIN)
                    begin
                        cmd.wr_kind = cfr_pkg::WR_PIN;
                    end
                    else if (sts.op == cfr_pkg::OP_UNPIN)
                    begin
                        cmd.wr_kind = cfr_pkg::WR_UNPIN;
                    end
                    else
                    begin
                        cmd.wr_kind = cfr_pkg::WR_TOUCH;
                    end
                end
            end
            OWNER_SCAN:
            begin
                if (sts.slot.valid && sts.owner_match)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_kind = (sts.op == cfr_pkg::OP_FREE_OWNER) ?
                                  cfr_pkg::WR_ZERO : cfr_pkg::WR_UNPIN;
                end
                if (sts.proc_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = cfr_pkg::RES_OK;
                    state_next   = FINISH;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    push_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_push |-> sts.out_free)
        else $error("Result pushed over a word that was not taken.");

    sweep_after_full_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SWEEP_START |->
            $past(state_reg) == ALLOC_SCAN && $past(sts.any_unpinned)
            && $past(sts.slot.valid))
        else $error("Sweep started without a full table and an unpinned slot.");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_clock_frame_replacement.sv -----
// Testbench of clock_frame_replacement: directed table, then random words against a predictor.
module tb_clock_frame_replacement;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES = 64;
    localparam logic [2:0] OP_SPARE = 3'd7;
    localparam int RANDOM_WORDS = 1250;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;
    localparam int IDLE_PCT = 37;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic       write_access;
        logic       mmap_page;
        logic [7:0] owner;
        logic [5:0] frame;
        logic [2:0] op;
    } frame_req_t;

    typedef struct packed {
        logic       victim_swap;
        logic       victim_writeback;
        logic [7:0] victim_owner;
        logic       evicted;
        logic [5:0] granted_frame;
        logic [1:0] status;
    } frame_res_t;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] frame;
        logic [7:0] owner;
        logic       mmap_page;
        logic       write_access;
        logic [6:0] count;
        logic       typed;
        logic [1:0] status;
        logic [5:0] granted;
    } plan_row_t;

    localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{cfr_pkg::OP_FREE, 6'd0, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_NOT_FOUND, 6'd0},
        '{cfr_pkg::OP_PIN, 6'd63, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_NOT_FOUND, 6'd0},
        '{cfr_pkg::OP_UNPIN, 6'd42, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_NOT_FOUND, 6'd0},
        '{cfr_pkg::OP_TOUCH, 6'd63, 8'd0, 1'b0, 1'b1, 7'd1, 1'b1, cfr_pkg::ST_NOT_FOUND, 6'd0},
        '{cfr_pkg::OP_FREE_OWNER, 6'd0, 8'd255, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_UNPIN_OWNER, 6'd0, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{OP_SPARE, 6'd63, 8'd255, 1'b1, 1'b1, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_ALLOC, 6'd0, 8'd255, 1'b1, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_ALLOC, 6'd0, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd1},
        '{cfr_pkg::OP_ALLOC, 6'd0, 8'd170, 1'b1, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd2},
        '{cfr_pkg::OP_TOUCH, 6'd0, 8'd0, 1'b0, 1'b1, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_TOUCH, 6'd1, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_UNPIN, 6'd0, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_PIN, 6'd1, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_FREE, 6'd1, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_ALLOC, 6'd0, 8'd85, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd1},
        '{cfr_pkg::OP_FREE_OWNER, 6'd0, 8'd85, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_FREE, 6'd1, 8'd0, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_NOT_FOUND, 6'd0},
        '{cfr_pkg::OP_UNPIN_OWNER, 6'd0, 8'd170, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_ALLOC, 6'd0, 8'd1, 1'b1, 1'b0, 7'd64, 1'b0, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_ALLOC, 6'd0, 8'd2, 1'b1, 1'b1, 7'd1, 1'b1, cfr_pkg::ST_OOM, 6'd0},
        '{cfr_pkg::OP_UNPIN_OWNER, 6'd0, 8'd1, 1'b0, 1'b0, 7'd1, 1'b1, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_TOUCH, 6'd5, 8'd0, 1'b0, 1'b1, 7'd1, 1'b0, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_ALLOC, 6'd0, 8'd2, 1'b0, 1'b0, 7'd3, 1'b0, cfr_pkg::ST_OK, 6'd0},
        '{cfr_pkg::OP_FREE_OWNER, 6'd0, 8'd1, 1'b0, 1'b0, 7'd1, 1'b0, cfr_pkg::ST_OK, 6'd0}
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cfr_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cfr_pkg::OUT_TDATA_W-1:0] m_tdata;

    cfr_pkg::slot_t frame_tbl [NUM_FRAMES];
    int             sweep_pos = 0;
    frame_res_t     expected_results [$];
    int             mismatch_count = 0;
    int             results_checked = 0;
    int             idle_pct = IDLE_PCT;
    int             hold_left = 0;
    bit             held_once = 1'b0;
    int             cycle_count = 0;

    clock_frame_replacement #(
        .NUM_FRAMES(NUM_FRAMES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #6 clk = ~clk;

    function automatic void claim_slot(input int k, input logic [7:0] owner, input logic mmap);
        frame_tbl[k]        = '0;
        frame_tbl[k].valid  = 1'b1;
        frame_tbl[k].pinned = 1'b1;
        frame_tbl[k].mmap   = mmap;
        frame_tbl[k].owner  = owner;
    endfunction

    function automatic frame_res_t frame_table_apply(input frame_req_t r);
        frame_res_t res;
        int         free_idx;
        int         i;
        int         s;
        bit         any_unpinned;
        bit         done;
        res = '0;
        case (r.op)
            cfr_pkg::OP_ALLOC:
            begin
                free_idx = -1;
                any_unpinned = 1'b0;
                for (i = NUM_FRAMES - 1; i >= 0; i--)
                begin
                    if (!frame_tbl[i].valid)
                        free_idx = i;
                    if (!frame_tbl[i].pinned)
                        any_unpinned = 1'b1;
                end
                if (free_idx >= 0)
                begin
                    claim_slot(free_idx, r.owner, r.mmap_page);
                    res.granted_frame = 6'(free_idx);
                end
                else if (!any_unpinned)
                    res.status = cfr_pkg::ST_OOM;
                else
                begin
                    done = 1'b0;
                    for (i = 0; i < 2 * NUM_FRAMES && !done; i++)
                    begin
                        s = sweep_pos;
                        sweep_pos = (s + 1) % NUM_FRAMES;
                        if (frame_tbl[s].pinned)
                            continue;
                        if (frame_tbl[s].accessed)
                            frame_tbl[s].accessed = 1'b0;
                        else
                        begin
                            done = 1'b1;
                            res.evicted = 1'b1;
                            res.victim_owner = frame_tbl[s].owner;
                            res.victim_writeback = frame_tbl[s].mmap & frame_tbl[s].dirty;
                            res.victim_swap = ~res.victim_writeback;
                            res.granted_frame = 6'(s);
                            claim_slot(s, r.owner, r.mmap_page);
                        end
                    end
                end
            end
            cfr_pkg::OP_FREE, cfr_pkg::OP_PIN, cfr_pkg::OP_UNPIN, cfr_pkg::OP_TOUCH:
            begin
                if (!frame_tbl[r.frame].valid)
                    res.status = cfr_pkg::ST_NOT_FOUND;
                else if (r.op == cfr_pkg::OP_FREE)
                    frame_tbl[r.frame] = '0;
                else if (r.op == cfr_pkg::OP_PIN)
                    frame_tbl[r.frame].pinned = 1'b1;
                else if (r.op == cfr_pkg::OP_UNPIN)
                    frame_tbl[r.frame].pinned = 1'b0;
                else
                begin
                    frame_tbl[r.frame].accessed = 1'b1;
                    if (r.write_access)
                        frame_tbl[r.frame].dirty = 1'b1;
                end
            end
            cfr_pkg::OP_FREE_OWNER, cfr_pkg::OP_UNPIN_OWNER:
            begin
                for (i = 0; i < NUM_FRAMES; i++)
                begin
                    if (frame_tbl[i].valid && frame_tbl[i].owner == r.owner)
                    begin
                        if (r.op == cfr_pkg::OP_FREE_OWNER)
                            frame_tbl[i] = '0;
                        else
                            frame_tbl[i].pinned = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [5:0] pick_frame();
        int         start;
        int         k;
        int         j;
        logic [5:0] f;
        start = $urandom_range(NUM_FRAMES - 1);
        f = 6'(start);
        if ($urandom_range(99) < 85)
        begin
            for (k = NUM_FRAMES - 1; k >= 0; k--)
            begin
                j = (start + k) % NUM_FRAMES;
                if (frame_tbl[j].valid)
                    f = 6'(j);
            end
        end
        return f;
    endfunction

    function automatic frame_req_t draw_request(input int mode);
        frame_req_t r;
        int         roll;
        roll = $urandom_range(99);
        r.frame = pick_frame();
        if ($urandom_range(3) == 0)
            r.owner = 8'($urandom_range(255));
        else
            r.owner = 8'($urandom_range(5));
        r.mmap_page = 1'($urandom_range(1));
        r.write_access = 1'($urandom_range(1));
        case (mode)
            0:
            begin
                if (roll < 80) r.op = cfr_pkg::OP_ALLOC;
                else if (roll < 92) r.op = cfr_pkg::OP_PIN;
                else r.op = cfr_pkg::OP_TOUCH;
            end
            1:
            begin
                if (roll < 30) r.op = cfr_pkg::OP_ALLOC;
                else if (roll < 50) r.op = cfr_pkg::OP_TOUCH;
                else if (roll < 64) r.op = cfr_pkg::OP_UNPIN;
                else if (roll < 71) r.op = cfr_pkg::OP_PIN;
                else if (roll < 80) r.op = cfr_pkg::OP_FREE;
                else if (roll < 86) r.op = cfr_pkg::OP_UNPIN_OWNER;
                else r.op = cfr_pkg::OP_FREE_OWNER;
            end
            2:
            begin
                if (roll < 45) r.op = cfr_pkg::OP_ALLOC;
                else if (roll < 70) r.op = cfr_pkg::OP_TOUCH;
                else if (roll < 86) r.op = cfr_pkg::OP_UNPIN;
                else r.op = cfr_pkg::OP_UNPIN_OWNER;
            end
            default:
            begin
                if (roll < 35) r.op = cfr_pkg::OP_FREE;
                else if (roll < 50) r.op = cfr_pkg::OP_FREE_OWNER;
                else if (roll < 60) r.op = cfr_pkg::OP_UNPIN_OWNER;
                else r.op = cfr_pkg::OP_ALLOC;
            end
        endcase
        if (mode != 0 && $urandom_range(99) < 6)
        begin
            r.op = 3'($urandom_range(7));
            r.frame = 6'($urandom_range(63));
        end
        return r;
    endfunction

    task automatic send_request(input frame_req_t r, input bit typed, input frame_res_t want);
        frame_res_t pred;
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cfr_pkg::IN_TDATA_W - $bits(frame_req_t)){1'b0}}, r};
        do
            @(posedge clk);
        while (!s_tready);
        pred = frame_table_apply(r);
        expected_results.push_back(typed ? want : pred);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] result %0d: %s", $realtime, results_checked, what);
    endtask

    initial
    begin
        frame_req_t req;
        frame_res_t want;
        int         n;
        int         k;
        int         mode;
        for (k = 0; k < NUM_FRAMES; k++)
            frame_tbl[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (n = 0; n < DIRECTED_ROWS; n++)
        begin
            for (k = 0; k < DIRECTED[n].count; k++)
            begin
                req.op = DIRECTED[n].op;
                req.frame = DIRECTED[n].frame;
                req.owner = DIRECTED[n].owner;
                req.mmap_page = DIRECTED[n].mmap_page;
                req.write_access = DIRECTED[n].write_access;
                want = '0;
                want.status = DIRECTED[n].status;
                want.granted_frame = DIRECTED[n].granted;
                send_request(req, DIRECTED[n].typed, want);
            end
        end
        mode = 0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0 && n != 0)
                mode = $urandom_range(3);
            if (n == 500)
                idle_pct <= 0;
            if (n == 700)
                idle_pct <= IDLE_PCT;
            req = draw_request(mode);
            send_request(req, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4 * NUM_FRAMES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!held_once && results_checked >= 300)
        begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        frame_res_t got;
        frame_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(frame_res_t)-1:0];
            results_checked <= results_checked + 1;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected word %h", m_tdata));
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                        got.status, want.status));
                if (got.granted_frame !== want.granted_frame)
                    report_mismatch($sformatf("granted_frame %0d, want %0d",
                        got.granted_frame, want.granted_frame));
                if (got.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %0d, want %0d",
                        got.evicted, want.evicted));
                if (got.victim_owner !== want.victim_owner)
                    report_mismatch($sformatf("victim_owner %0d, want %0d",
                        got.victim_owner, want.victim_owner));
                if (got.victim_writeback !== want.victim_writeback)
                    report_mismatch($sformatf("victim_writeback %0d, want %0d",
                        got.victim_writeback, want.victim_writeback));
                if (got.victim_swap !== want.victim_swap)
                    report_mismatch($sformatf("victim_swap %0d, want %0d",
                        got.victim_swap, want.victim_swap));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
